FILE: rtl/deadline_job_profit_scheduler_top_defines.svh
// Assertion macros shared by the scheduler modules.
`ifndef DEADLINE_JOB_PROFIT_SCHEDULER_TOP_DEFINES_SVH
`define DEADLINE_JOB_PROFIT_SCHEDULER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DJPS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DJPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DJPS_ASSERT(lbl, clk, rstn, prop, msg)
`define DJPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/djps_pkg.sv
`timescale 1ns / 1ps
package djps_pkg;
    localparam int PROFIT_W = 16;
    localparam int DL_W     = 11;
    localparam int TOTAL_W  = 26;

    typedef struct packed {
        logic load;
        logic start;
        logic scan;
        logic commit;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic day_zero;
        logic scan_done;
        logic last_day;
    } t_stat;
endpackage

FILE: rtl/djps_ctrl.sv
`timescale 1ns / 1ps
`include "deadline_job_profit_scheduler_top_defines.svh"
module djps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_last_job,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  djps_pkg::t_stat i_stat,
    output djps_pkg::t_cmd  o_cmd
);
    import djps_pkg::*;

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid && i_last_job) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state = i_stat.day_zero ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = i_stat.last_day ? S_DONE : S_SCAN;
            end
            S_DONE: begin
                o_valid     = 1'b1;
                o_cmd.clear = i_ready;
                if (i_ready) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    `DJPS_ASSERT(a_cmd_onehot, i_clk, i_rst_n, $onehot0(o_cmd), "more than one command at once")
    `DJPS_ASSERT(a_no_load_while_out, i_clk, i_rst_n, !(o_valid && o_ready), "load during result")
    `DJPS_ASSERT(a_commit_after_scan, i_clk, i_rst_n, o_cmd.commit |-> $past(o_cmd.scan), "commit without scan")
endmodule

FILE: rtl/djps_datapath.sv
`timescale 1ns / 1ps
`include "deadline_job_profit_scheduler_top_defines.svh"
module djps_datapath #(
    parameter int MAX_JOBS     = 1024,
    parameter int MAX_DEADLINE = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  djps_pkg::t_cmd                   i_cmd,
    output djps_pkg::t_stat                  o_stat,
    input  logic [djps_pkg::PROFIT_W-1:0]    i_job_profit,
    input  logic [djps_pkg::DL_W-1:0]        i_job_deadline,
    output logic [djps_pkg::TOTAL_W-1:0]     o_total_profit
);
    import djps_pkg::*;

    localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam logic [16:0] MAX_DL_L = 17'(MAX_DEADLINE);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_JOBS);

    logic [PROFIT_W-1:0] profit_mem [MAX_JOBS];
    logic [DL_W-1:0]     dl_mem     [MAX_JOBS];

    logic [CW-1:0]       r_cnt;
    logic [DL_W-1:0]     r_maxdl;
    logic [DL_W-1:0]     r_day;
    logic [CW-1:0]       r_idx;
    logic [AW-1:0]       r_ridx;
    logic                r_rv;
    logic [PROFIT_W-1:0] r_rd_p;
    logic [DL_W-1:0]     r_rd_dl;
    logic                r_found;
    logic [PROFIT_W-1:0] r_best_p;
    logic [AW-1:0]       r_best_i;
    logic [TOTAL_W-1:0]  r_total;

    logic [DL_W-1:0]     dl_clamp;
    logic                store_ok;
    logic                issue;
    logic                better;

    assign dl_clamp = ({6'b0, i_job_deadline} > MAX_DL_L) ? MAX_DL_L[DL_W-1:0]
                                                          : i_job_deadline;
    assign store_ok = i_cmd.load && (r_cnt < MAX_CNT);
    assign issue    = i_cmd.scan && (r_idx < r_cnt);
    assign better   = r_rv && (r_rd_dl >= r_day) && (!r_found || (r_rd_p > r_best_p));

    assign o_stat.day_zero  = (r_maxdl == '0);
    assign o_stat.scan_done = (r_idx == r_cnt) && !r_rv;
    assign o_stat.last_day  = (r_day == DL_W'(1));
    assign o_total_profit   = r_total;

    // A job that is taken gets its deadline cleared so later days skip it.
    always_ff @(posedge i_clk) begin
        if (store_ok) begin
            profit_mem[r_cnt[AW-1:0]] <= i_job_profit;
            dl_mem[r_cnt[AW-1:0]]     <= dl_clamp;
        end else if (i_cmd.commit && r_found) begin
            dl_mem[r_best_i] <= '0;
        end
        if (issue) begin
            r_rd_p  <= profit_mem[r_idx[AW-1:0]];
            r_rd_dl <= dl_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_maxdl <= '0;
            r_rv    <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
            r_day   <= '0;
            r_total <= '0;
        end else begin
            r_rv <= issue;
            if (store_ok) begin
                r_cnt <= r_cnt + CW'(1);
                if (dl_clamp > r_maxdl) begin
                    r_maxdl <= dl_clamp;
                end
            end
            if (i_cmd.start) begin
                r_day   <= r_maxdl;
                r_idx   <= '0;
                r_found <= 1'b0;
                r_total <= '0;
            end
            if (issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_found) begin
                    r_total <= r_total + TOTAL_W'(r_best_p);
                end
                r_day   <= r_day - DL_W'(1);
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_cnt   <= '0;
                r_maxdl <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_ridx <= r_idx[AW-1:0];
        end
        if (better) begin
            r_best_p <= r_rd_p;
            r_best_i <= r_ridx;
        end
    end

    `DJPS_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= MAX_CNT, "job count past capacity")
    `DJPS_ASSERT(a_read_in_scan, i_clk, i_rst_n, r_rv |-> $past(i_cmd.scan), "read outside scan")
    `DJPS_ASSERT(a_idx_bound, i_clk, i_rst_n, i_cmd.scan |-> (r_idx <= r_cnt), "scan index overrun")
endmodule

FILE: rtl/deadline_job_profit_scheduler_top.sv
`timescale 1ns / 1ps
// Jobs load at one per cycle while the block waits for a batch.
// After the last job, each day from the largest deadline down to 1 takes one scan of the
// N stored jobs through the job memory read port plus a commit step.
// The next batch loads once the result is taken.
// Reset (synchronous, active low) empties the batch; the memories keep contents.
module deadline_job_profit_scheduler_top #(
    parameter int MAX_JOBS     = 1024,
    parameter int MAX_DEADLINE = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [djps_pkg::PROFIT_W-1:0] i_job_profit,
    input  logic [djps_pkg::DL_W-1:0]     i_job_deadline,
    input  logic                          i_last_job,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [djps_pkg::TOTAL_W-1:0]  o_total_profit
);
    import djps_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    djps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_last_job (i_last_job),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    djps_datapath #(
        .MAX_JOBS     (MAX_JOBS),
        .MAX_DEADLINE (MAX_DEADLINE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_job_profit   (i_job_profit),
        .i_job_deadline (i_job_deadline),
        .o_total_profit (o_total_profit)
    );
endmodule

FILE: tb/sv/deadline_job_profit_scheduler_top_tb.sv
`timescale 1ns / 1ps
module deadline_job_profit_scheduler_top_tb;
    import djps_pkg::*;

    localparam int MAX_JOBS     = 1024;
    localparam int MAX_DEADLINE = 1024;
    localparam int STALL_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 108;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [PROFIT_W-1:0] i_job_profit;
    logic [DL_W-1:0]     i_job_deadline;
    logic                i_last_job;
    logic                o_valid;
    logic                i_ready;
    logic [TOTAL_W-1:0]  o_total_profit;

    deadline_job_profit_scheduler_top #(
        .MAX_JOBS     (MAX_JOBS),
        .MAX_DEADLINE (MAX_DEADLINE)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_job_profit   (i_job_profit),
        .i_job_deadline (i_job_deadline),
        .i_last_job     (i_last_job),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_total_profit (o_total_profit)
    );

    typedef struct {
        logic [PROFIT_W-1:0] profit;
        logic [DL_W-1:0]     deadline;
        logic                last;
        bit                  has_total;
        logic [TOTAL_W-1:0]  total;
    } t_job_row;

    // Batch held by the predictor, cleared after each total.
    int unsigned batch_profit[$];
    int unsigned batch_deadline[$];
    int unsigned batch_largest;

    logic [TOTAL_W-1:0] expected_totals[$];

    int  fail_count;
    int  items_sent;
    int  totals_seen;
    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  hold_request;
    int  hold_left;
    int  quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Greedy schedule: walk days downward, pool eligible jobs, take the best.
    function automatic logic [TOTAL_W-1:0] greedy_total();
        int unsigned pool[$];
        int unsigned sum;
        int          best;
        sum = 0;
        for (int day = batch_largest; day >= 1; day--) begin
            for (int k = 0; k < batch_profit.size(); k++)
                if (batch_deadline[k] == day)
                    pool = {pool, batch_profit[k]};
            if (pool.size() > 0) begin
                best = 0;
                for (int k = 1; k < pool.size(); k++)
                    if (pool[k] > pool[best])
                        best = k;
                sum = (sum + pool[best]) & ((1 << TOTAL_W) - 1);
                pool.delete(best);
            end
        end
        return sum[TOTAL_W-1:0];
    endfunction

    // Returns 1 when the job closes a batch; total is then valid.
    function automatic bit predict_job(logic [PROFIT_W-1:0] profit,
                                       logic [DL_W-1:0] deadline, logic last,
                                       output logic [TOTAL_W-1:0] total);
        int unsigned dl;
        dl = (deadline > MAX_DEADLINE) ? MAX_DEADLINE : deadline;
        if (batch_profit.size() < MAX_JOBS) begin
            batch_profit   = {batch_profit, int'(profit)};
            batch_deadline = {batch_deadline, dl};
            if (dl > batch_largest)
                batch_largest = dl;
        end
        total = '0;
        if (!last)
            return 0;
        total = greedy_total();
        batch_profit.delete();
        batch_deadline.delete();
        batch_largest = 0;
        return 1;
    endfunction

    task automatic send_job(t_job_row row);
        logic [TOTAL_W-1:0] total;
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_job_profit   <= row.profit;
        i_job_deadline <= row.deadline;
        i_last_job     <= row.last;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (predict_job(row.profit, row.deadline, row.last, total))
            expected_totals = {expected_totals, (row.has_total ? row.total : total)};
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain_totals();
        end_burst();
        while (expected_totals.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic random_batch(int items_left);
        t_job_row row;
        int       len;
        int       dl_max;
        bit       wide;
        wide = ($urandom_range(39) == 0);
        len  = wide ? $urandom_range(1, 4) : $urandom_range(1, 8);
        if (len > items_left)
            len = (items_left > 0) ? items_left : 1;
        dl_max = wide ? 2047 : $urandom_range(1, len + 3);
        for (int k = 0; k < len; k++) begin
            row.profit    = $urandom_range(9) == 0 ? {PROFIT_W{1'b1}} : $urandom;
            row.deadline  = $urandom_range(dl_max);
            row.last      = (k == len - 1);
            row.has_total = 0;
            send_job(row);
        end
    endtask

    // Drives i_ready backpressure on the result side; a hold request keeps it low for a long stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            totals_seen++;
            if (expected_totals.size() == 0) begin
                $error("total_profit: unexpected transfer, actual %0d", o_total_profit);
                fail_count++;
            end else begin
                if (o_total_profit !== expected_totals[0]) begin
                    $error("total_profit: expected %0d, actual %0d",
                           expected_totals[0], o_total_profit);
                    fail_count++;
                end
                void'(expected_totals.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d totals outstanding", expected_totals.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_job_row directed[$];
        int       start_items;
        fail_count        = 0;
        items_sent        = 0;
        totals_seen       = 0;
        hold_request      = 0;
        hold_left         = 0;
        quiet_cycles      = 0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        batch_largest     = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_job_profit   = '0;
        i_job_deadline = '0;
        i_last_job     = 1'b0;
        i_ready        = 1'b0;

        // Single job, zero deadline, clamped deadline with extreme profits,
        // contention for early days, zero profit, and a mix checked against the predictor.
        directed = '{
            '{16'd100,   11'd1,    1'b1, 1, 26'd100},
            '{16'd5,     11'd0,    1'b1, 1, 26'd0},
            '{16'hFFFF,  11'd2047, 1'b0, 0, 26'd0},
            '{16'hFFFF,  11'd1024, 1'b0, 0, 26'd0},
            '{16'd1,     11'd1,    1'b1, 1, 26'd131071},
            '{16'd10,    11'd2,    1'b0, 0, 26'd0},
            '{16'd20,    11'd1,    1'b0, 0, 26'd0},
            '{16'd30,    11'd1,    1'b0, 0, 26'd0},
            '{16'd5,     11'd2,    1'b1, 1, 26'd40},
            '{16'd0,     11'd3,    1'b0, 0, 26'd0},
            '{16'd7,     11'd1024, 1'b1, 1, 26'd7},
            '{16'd0,     11'd0,    1'b1, 1, 26'd0},
            '{16'd1234,  11'd5,    1'b0, 0, 26'd0},
            '{16'd999,   11'd3,    1'b0, 0, 26'd0},
            '{16'd50,    11'd5,    1'b1, 0, 26'd0}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_job(directed[i]);
        drain_totals();

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct   = (phase == 0) ? 7 : (phase == 1) ? 67 : 0;
            receiver_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 7 : 0;
            if (phase == 2)
                hold_request = 3000;
            start_items = items_sent;
            while (items_sent - start_items < RANDOM_ITEMS / 3) begin
                random_batch(RANDOM_ITEMS / 3 - (items_sent - start_items));
                if (phase == 1 && items_sent - start_items > RANDOM_ITEMS / 6
                        && batch_profit.size() == 0 && start_items >= 0) begin
                    // Oversized batch: jobs past the capacity are dropped,
                    // and the closing mark rides on a dropped job.
                    t_job_row row;
                    for (int k = 0; k < MAX_JOBS + 6; k++) begin
                        row.profit    = $urandom;
                        row.deadline  = $urandom_range(2);
                        row.last      = (k == MAX_JOBS + 5);
                        row.has_total = 0;
                        send_job(row);
                    end
                    start_items = -items_sent;
                end
                if (start_items < 0 && phase == 1)
                    start_items = items_sent - RANDOM_ITEMS / 3 - 1;
            end
            drain_totals();
        end

        repeat (50) @(posedge i_clk);
        $display("Sent %0d jobs and checked %0d batch totals across three backpressure mixes,",
                 items_sent, totals_seen);
        $display("including clamped deadlines, zero deadlines and one oversized batch.");
        if (fail_count == 0 && expected_totals.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
